// File: rtl/ple_pkg.sv
// ple_pkg: shared constants, request/result structs and control codes
// for the positional list engine. No dependencies.
`timescale 1ns / 1ps

package ple_pkg;

  localparam int CAPACITY    = 256;
  localparam int VALUE_WIDTH = 32;

  // field widths fixed by the interface
  localparam int OP_W  = 3;
  localparam int POS_W = 9;
  localparam int LEN_W = 9;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  // read tree: first stage merges groups of this many cells
  localparam int GROUP  = 16;
  localparam int NGROUP = (CAPACITY + GROUP - 1) / GROUP;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT  = 3'd0,
    OP_REMOVE  = 3'd1,
    OP_GET     = 3'd2,
    OP_REPLACE = 3'd3,
    OP_CLEAR   = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL,
    CELL_WR,
    CELL_RD
  } cell_act_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_GATHER,
    S_MERGE
  } state_e;

  typedef struct packed {
    logic [OP_W-1:0]        operation;
    logic [POS_W-1:0]       position;
    logic [VALUE_WIDTH-1:0] entry_value;
  } req_t;

  typedef struct packed {
    logic                   ok;
    logic [VALUE_WIDTH-1:0] read_value;
    logic [LEN_W-1:0]       length;
    logic                   empty_res;
  } rsp_t;

  // command broadcast to every cell of the chain
  typedef struct packed {
    cell_act_e              act;
    logic [CMP_W-1:0]       idx;
    logic [VALUE_WIDTH-1:0] value;
  } cell_cmd_t;

endpackage

// File: rtl/ple_cell.sv
// ple_cell: one list slot; holds an entry, shifts with its neighbors,
// and offers its entry to the read tree. Depends on ple_pkg.
`timescale 1ns / 1ps

module ple_cell (
  input  logic                           clk,
  input  logic [ple_pkg::IDX_W-1:0]      slot,
  input  ple_pkg::cell_cmd_t             cmd,
  input  logic [ple_pkg::VALUE_WIDTH-1:0] left,
  input  logic [ple_pkg::VALUE_WIDTH-1:0] right,
  output logic [ple_pkg::VALUE_WIDTH-1:0] entry,
  output logic [ple_pkg::VALUE_WIDTH-1:0] leaf
);
  import ple_pkg::*;

  logic [CMP_W-1:0] slot_ext;
  logic             hit;
  logic             above;

  assign slot_ext = CMP_W'(slot);
  assign hit      = (slot_ext == cmd.idx);
  assign above    = (slot_ext > cmd.idx);

  always_ff @(posedge clk) begin
    case (cmd.act)
      CELL_INS: begin
        // open a gap at idx, everything above moves up one slot
        if (above) begin
          entry <= left;
        end else if (hit) begin
          entry <= cmd.value;
        end
      end
      CELL_DEL: begin
        if (hit || above) begin
          entry <= right;
        end
      end
      CELL_WR: begin
        if (hit) begin
          entry <= cmd.value;
        end
      end
      default: begin
        entry <= entry;
      end
    endcase
  end

  // only the addressed cell feeds the or-tree
  always_ff @(posedge clk) begin
    if (cmd.act == CELL_RD && hit) begin
      leaf <= entry;
    end else begin
      leaf <= '0;
    end
  end

endmodule

// File: rtl/ple_read_tree.sv
// ple_read_tree: registered or-tree that merges the cell leaves into one
// read value; the group results are registered. Depends on ple_pkg.
`timescale 1ns / 1ps

module ple_read_tree (
  input  logic                            clk,
  input  logic [ple_pkg::VALUE_WIDTH-1:0] leaves [ple_pkg::CAPACITY],
  output logic [ple_pkg::VALUE_WIDTH-1:0] merged
);
  import ple_pkg::*;

  logic [VALUE_WIDTH-1:0] group_or [NGROUP];
  logic [VALUE_WIDTH-1:0] group_q  [NGROUP];

  always_comb begin
    for (int g = 0; g < NGROUP; g++) begin
      group_or[g] = '0;
      for (int k = 0; k < GROUP; k++) begin
        if (g * GROUP + k < CAPACITY) begin
          group_or[g] = group_or[g] | leaves[g * GROUP + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < NGROUP; g++) begin
      group_q[g] <= group_or[g];
    end
  end

  always_comb begin
    merged = '0;
    for (int g = 0; g < NGROUP; g++) begin
      merged = merged | group_q[g];
    end
  end

endmodule

// File: rtl/positional_list_engine.sv
// positional_list_engine: top level; request decode, count register,
// control sequencer, chain of ple_cell and ple_read_tree. Depends on ple_pkg.
//
// Usage:
//   A request (insert, remove, get, replace, clear) is taken at a rising
//   edge where start is high and busy is low. Positions are 1-based.
//   The list is a row of cells, one per slot; insert and remove shift all
//   cells at once in the accept cycle, so the list itself updates at once.
//   A get reads through a two-stage registered or-tree over the cells.
//   Every request gives one result: done is high for exactly one cycle,
//   with result valid in that cycle; a get passes the leaf and group registers.
//   busy stays high from the accept edge until the edge that raises done,
//   so a new request is taken only once the previous one has finished.
//   The receiver cannot stall; result is held until the next request's result.
//   Reset (rst, synchronous) empties the list and drops any request in
//   flight; busy is high while rst is held. Cell contents are not cleared
//   and are reachable only after being written.
`timescale 1ns / 1ps

module positional_list_engine (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  ple_pkg::req_t  request,
  output logic           done,
  output ple_pkg::rsp_t  result
);
  import ple_pkg::*;

  state_e                 state;
  state_e                 state_next;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       count_next;
  logic                   ok_q;
  logic                   ok_c;
  logic                   accept;
  cell_cmd_t              cmd;
  logic [CMP_W-1:0]       pos_ext;
  logic [CMP_W:0]         cnt_ext;
  logic                   pos_nz;
  logic                   pos_in;
  logic                   pos_in_ins;
  logic                   not_full;
  logic [VALUE_WIDTH-1:0] entries [CAPACITY];
  logic [VALUE_WIDTH-1:0] leaves  [CAPACITY];
  logic [VALUE_WIDTH-1:0] merged;

  assign accept     = start && !busy;
  assign pos_ext    = CMP_W'(request.position);
  assign cnt_ext    = (CMP_W + 1)'(count);
  assign pos_nz     = (request.position != '0);
  assign pos_in     = pos_nz && ({1'b0, pos_ext} <= cnt_ext);
  assign pos_in_ins = pos_nz && ({1'b0, pos_ext} <= cnt_ext + 1'b1);
  assign not_full   = (count < CNT_W'(CAPACITY));

  // request decode
  always_comb begin
    cmd.act    = CELL_HOLD;
    cmd.idx    = pos_ext - 1'b1;
    cmd.value  = request.entry_value;
    ok_c       = 1'b0;
    count_next = count;
    if (accept) begin
      case (request.operation)
        OP_INSERT: begin
          if (pos_in_ins && not_full) begin
            cmd.act    = CELL_INS;
            ok_c       = 1'b1;
            count_next = count + 1'b1;
          end
        end
        OP_REMOVE: begin
          if (pos_in) begin
            cmd.act    = CELL_DEL;
            ok_c       = 1'b1;
            count_next = count - 1'b1;
          end
        end
        OP_GET: begin
          if (pos_in) begin
            cmd.act = CELL_RD;
            ok_c    = 1'b1;
          end
        end
        OP_REPLACE: begin
          if (pos_in) begin
            cmd.act = CELL_WR;
            ok_c    = 1'b1;
          end
        end
        OP_CLEAR: begin
          ok_c       = 1'b1;
          count_next = '0;
        end
        default: begin
          ok_c = 1'b0;
        end
      endcase
    end
  end

  // cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] left_v;
    logic [VALUE_WIDTH-1:0] right_v;

    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = entries[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = entries[i+1];
    end

    ple_cell u_cell (
      .clk   (clk),
      .slot  (IDX_W'(i)),
      .cmd   (cmd),
      .left  (left_v),
      .right (right_v),
      .entry (entries[i]),
      .leaf  (leaves[i])
    );
  end

  ple_read_tree u_tree (
    .clk    (clk),
    .leaves (leaves),
    .merged (merged)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b1;
    case (state)
      S_IDLE: begin
        // no request is taken while reset is held
        busy = rst;
        if (accept) begin
          state_next = S_GATHER;
        end
      end
      S_GATHER: begin
        state_next = S_MERGE;
      end
      S_MERGE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ok_q <= ok_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == S_MERGE);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_MERGE) begin
      result.ok         <= ok_q;
      result.read_value <= merged;
      result.length     <= LEN_W'(count);
      result.empty_res  <= (count == '0);
    end
  end

  a_done_after_merge: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_MERGE))
    else $error("done without a merge cycle");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("busy low right after a request was taken");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("count beyond capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (cmd.act == CELL_INS) |=> (count == $past(count) + 1'b1))
    else $error("insert did not grow the list");

  a_read_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    (done && !result.ok) |-> (result.read_value == '0))
    else $error("read value nonzero on a rejected request");

endmodule

// File: sim/tb_top.sv
// tb_top: self-checking bench for positional_list_engine; a queued request
// driver, a result monitor and an in-bench list predictor. Depends on ple_pkg.
`timescale 1ns / 1ps

module tb_top;
  import ple_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED_LO  = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_MID = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_HI  = 3'd7;
  localparam int RAND_ITEMS = 500;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  start = 1'b0;
  logic  busy;
  req_t  request = '0;
  logic  done;
  rsp_t  result;

  positional_list_engine uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .done(done),
    .result(result)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // predicted list contents
  logic [VALUE_WIDTH-1:0] list_mem [CAPACITY];
  int                     list_len = 0;

  req_t pending_req_q [$];
  rsp_t expected_rsp_q [$];
  int   err_count = 0;
  logic req_taken = 1'b0;
  int   gap_left = 0;
  int   burst_left = 1;

  // list length as seen by the request generator
  int gen_len = 0;

  function automatic rsp_t predict_list_op(req_t r);
    rsp_t e;
    int   pos;
    pos = r.position;
    e = '0;
    case (r.operation)
      OP_INSERT: begin
        if (pos >= 1 && pos <= list_len + 1 && list_len < CAPACITY) begin
          for (int i = list_len; i >= pos; i--) list_mem[i] = list_mem[i-1];
          list_mem[pos-1] = r.entry_value;
          list_len++;
          e.ok = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (pos >= 1 && pos <= list_len) begin
          for (int i = pos; i < list_len; i++) list_mem[i-1] = list_mem[i];
          list_len--;
          e.ok = 1'b1;
        end
      end
      OP_GET: begin
        if (pos >= 1 && pos <= list_len) begin
          e.read_value = list_mem[pos-1];
          e.ok = 1'b1;
        end
      end
      OP_REPLACE: begin
        if (pos >= 1 && pos <= list_len) begin
          list_mem[pos-1] = r.entry_value;
          e.ok = 1'b1;
        end
      end
      OP_CLEAR: begin
        list_len = 0;
        e.ok = 1'b1;
      end
      default: begin
      end
    endcase
    e.length = list_len[LEN_W-1:0];
    e.empty_res = (list_len == 0);
    return e;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("tb_top: mismatch %s got %h want %h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  task automatic queue_req(logic [OP_W-1:0] op, int pos, logic [VALUE_WIDTH-1:0] val);
    req_t r;
    r.operation = op;
    r.position = pos[POS_W-1:0];
    r.entry_value = val;
    pending_req_q.push_back(r);
    pos = r.position;
    case (op)
      OP_INSERT:
        if (pos >= 1 && pos <= gen_len + 1 && gen_len < CAPACITY) gen_len++;
      OP_REMOVE:
        if (pos >= 1 && pos <= gen_len) gen_len--;
      OP_CLEAR:
        gen_len = 0;
      default: begin
      end
    endcase
  endtask

  // mostly valid positions, now and then just outside the range
  function automatic int pick_pos(logic [OP_W-1:0] op);
    int hi;
    hi = (op == OP_INSERT) ? gen_len + 1 : gen_len;
    case ($urandom_range(0, 9))
      0: return 0;
      1: return hi + 1;
      default: return (hi >= 1) ? $urandom_range(1, hi) : 1;
    endcase
  endfunction

  task automatic queue_formed(int insert_pct);
    logic [OP_W-1:0] op;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < insert_pct || gen_len == 0) op = OP_INSERT;
    else if (roll < insert_pct + (100 - insert_pct) / 3) op = OP_REMOVE;
    else if ($urandom_range(0, 40) == 0) op = OP_CLEAR;
    else if (roll[0]) op = OP_GET;
    else op = OP_REPLACE;
    queue_req(op, pick_pos(op), $urandom);
  endtask

  task automatic build_stimulus();
    int n;
    int kind;
    int len;
    int fill_at;
    bit filled;
    // directed part
    queue_req(OP_GET, 1, '0);
    queue_req(OP_REMOVE, 1, '0);
    queue_req(OP_REPLACE, 1, 32'h1234_5678);
    queue_req(OP_INSERT, 0, 32'hdead_beef);
    queue_req(OP_INSERT, 2, 32'hdead_beef);
    queue_req(OP_INSERT, 1, 32'h0000_0000);
    queue_req(OP_INSERT, 2, 32'hffff_ffff);
    queue_req(OP_INSERT, 1, 32'ha5a5_a5a5);
    queue_req(OP_INSERT, 4, 32'h5a5a_5a5a);
    queue_req(OP_GET, 1, 32'hffff_ffff);
    queue_req(OP_GET, 2, '0);
    queue_req(OP_GET, 4, '0);
    queue_req(OP_GET, 5, '0);
    queue_req(OP_GET, 511, '0);
    queue_req(OP_REPLACE, 3, 32'h8000_0001);
    queue_req(OP_GET, 3, '0);
    queue_req(OP_REMOVE, 2, '0);
    queue_req(OP_REMOVE, 0, '0);
    queue_req(OP_REMOVE, 4, '0);
    queue_req(OP_GET, 2, '0);
    queue_req(OP_UNUSED_LO, 1, 32'hffff_ffff);
    queue_req(OP_UNUSED_MID, 511, 32'h0f0f_0f0f);
    queue_req(OP_UNUSED_HI, 2, '0);
    queue_req(OP_CLEAR, 511, 32'hffff_ffff);
    queue_req(OP_GET, 1, '0);

    // random part in phases: grow, shrink, mixed, noise, plus one fill to full
    n = 0;
    filled = 0;
    fill_at = $urandom_range(80, 250);
    while (n < RAND_ITEMS) begin
      if (!filled && n >= fill_at) begin
        filled = 1;
        while (gen_len < CAPACITY) begin
          queue_req(OP_INSERT, $urandom_range(1, gen_len + 1), $urandom);
          n++;
        end
        queue_req(OP_INSERT, 1, $urandom);
        queue_req(OP_INSERT, CAPACITY + 1, $urandom);
        queue_req(OP_INSERT, CAPACITY, $urandom);
        queue_req(OP_GET, CAPACITY, '0);
        queue_req(OP_GET, CAPACITY + 1, '0);
        queue_req(OP_REPLACE, CAPACITY, $urandom);
        queue_req(OP_GET, CAPACITY, '0);
        queue_req(OP_GET, 1, '0);
        queue_req(OP_REMOVE, CAPACITY, '0);
        queue_req(OP_INSERT, CAPACITY, $urandom);
        queue_req(OP_REMOVE, 1, '0);
        n += 11;
      end
      kind = $urandom_range(0, 9);
      len = $urandom_range(5, 30);
      for (int k = 0; k < len; k++) begin
        if (kind < 3) queue_formed(70);
        else if (kind < 5) queue_formed(15);
        else if (kind < 9) queue_formed(35);
        else queue_req(OP_W'($urandom_range(0, 7)), $urandom_range(0, 511), $urandom);
        n++;
      end
    end
  endtask

  // driver: bursts of requests separated by random gaps
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !req_taken) begin
      // request still waiting for busy to drop
    end else if (gap_left > 0) begin
      gap_left--;
      start <= 1'b0;
    end else if (pending_req_q.size() > 0) begin
      request <= pending_req_q.pop_front();
      start <= 1'b1;
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 30);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end
    end else begin
      start <= 1'b0;
    end
  end

  // monitor: check results first, then predict the request taken at this edge
  always @(posedge clk) begin
    rsp_t want;
    req_taken <= start && !busy && !rst;
    if (!rst) begin
      if (done) begin
        if (expected_rsp_q.size() == 0) begin
          report_mismatch("unexpected result", {31'b0, result.ok}, '0);
        end else begin
          want = expected_rsp_q.pop_front();
          if (result.ok !== want.ok)
            report_mismatch("ok", {31'b0, result.ok}, {31'b0, want.ok});
          if (result.read_value !== want.read_value)
            report_mismatch("read_value", result.read_value, want.read_value);
          if (result.length !== want.length)
            report_mismatch("length", {23'b0, result.length}, {23'b0, want.length});
          if (result.empty_res !== want.empty_res)
            report_mismatch("empty_res", {31'b0, result.empty_res}, {31'b0, want.empty_res});
        end
      end
      if (start && !busy) expected_rsp_q.push_back(predict_list_op(request));
    end
  end

  initial begin
    build_stimulus();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    while (pending_req_q.size() != 0 || start || expected_rsp_q.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (expected_rsp_q.size() != 0)
      report_mismatch("missing results", expected_rsp_q.size(), '0);
    if (err_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("tb_top: timeout");
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

// File: positional_list_engine.f
rtl/ple_pkg.sv
rtl/ple_cell.sv
rtl/ple_read_tree.sv
rtl/positional_list_engine.sv
sim/tb_top.sv
